>>> rtl/lcc_pkg.sv
// Shared types and constants for the recency-ordered cell cache.
// No dependencies; imported by every module of the block.
`default_nettype none
package lcc_pkg;

  localparam int ADDR_W = 16;
  localparam int DATA_W = 32;

  localparam int ENTRIES_DEF   = 16;
  localparam int ADDR_BITS_DEF = 16;
  localparam int DATA_BITS_DEF = 32;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  typedef struct packed {
    logic match;
    logic repl;
    logic dirty;
  } cell_stat_t;

endpackage
`default_nettype wire

>>> rtl/lcc_cell.sv
// One cache slot of the recency row: holds key, value, valid and dirty.
// Depends on lcc_pkg; loads its lower neighbor's contents on a shift.
`default_nettype none
module lcc_cell #(
  parameter int ADDR_BITS = 16,
  parameter int DATA_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire logic                   prev_valid,
  input  wire logic                   prev_dirty,
  input  wire logic [ADDR_BITS-1:0]   prev_key,
  input  wire logic [DATA_BITS-1:0]   prev_value,
  input  wire logic [ADDR_BITS-1:0]   probe_key,
  output logic                        valid,
  output logic                        dirty,
  output logic [ADDR_BITS-1:0]        key,
  output logic [DATA_BITS-1:0]        value,
  output lcc_pkg::cell_stat_t         stat
);
  import lcc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      dirty <= 1'b0;
    end else if (load) begin
      valid <= prev_valid;
      dirty <= prev_dirty;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key   <= prev_key;
      value <= prev_value;
    end
  end

  always_comb begin
    stat.match = valid && (key == probe_key);
    stat.repl  = !valid || !dirty;
    stat.dirty = dirty;
  end

endmodule
`default_nettype wire

>>> rtl/lcc_ctrl.sv
// Sequencer of the cell row: latches the word and the compare results,
// then picks hit or victim, drives the shift enables and the result.
// Depends on lcc_pkg.
`default_nettype none
module lcc_ctrl #(
  parameter int ENTRIES   = 16,
  parameter int ADDR_BITS = 16,
  parameter int DATA_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic                                opcode,
  input  wire logic [ADDR_BITS-1:0]                key_in,
  input  wire logic [DATA_BITS-1:0]                wdata_in,
  input  wire logic [DATA_BITS-1:0]                bdata_in,
  input  wire lcc_pkg::cell_stat_t [ENTRIES-1:0]   stat,
  input  wire logic [ENTRIES-1:0][DATA_BITS-1:0]   values,
  output logic                                     busy,
  output logic [ENTRIES-1:0]                       load,
  output logic [ADDR_BITS-1:0]                     new_key,
  output logic [DATA_BITS-1:0]                     new_value,
  output logic                                     new_dirty,
  output logic                                     done,
  output logic [DATA_BITS-1:0]                     rd,
  output logic                                     hit_q,
  output logic                                     chg_q,
  output logic                                     status_q
);
  import lcc_pkg::*;

  localparam int LOG_E = $clog2(ENTRIES);

  state_t                 state, state_next;
  logic                   halted, halted_next;
  logic                   op_q;
  logic [ADDR_BITS-1:0]   key_q;
  logic [DATA_BITS-1:0]   wdata_q, bdata_q;
  logic [ENTRIES-1:0]     match_q, repl_q;

  logic                   any_hit, any_repl, hit_dirty, is_write, move;
  logic [DATA_BITS-1:0]   hit_val;
  logic [ENTRIES-1:0]     sel_src, sfx;
  logic                   done_next, hit_next, chg_next, status_next;
  logic [DATA_BITS-1:0]   rd_next;

  assign busy     = (state == ST_BUSY);
  assign is_write = (op_q == OP_WRITE);
  assign any_hit  = |match_q;
  assign any_repl = |repl_q;
  assign new_key  = key_q;

  always_comb begin
    hit_val   = '0;
    hit_dirty = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_val   = hit_val | (values[i] & {DATA_BITS{match_q[i]}});
      hit_dirty = hit_dirty | (match_q[i] & stat[i].dirty);
    end
  end

  // bit i set when some selected position at or behind i exists
  always_comb begin
    sel_src = any_hit ? match_q : repl_q;
    sfx     = sel_src;
    for (int k = 0; k < LOG_E; k++) begin
      sfx = sfx | (sfx >> (1 << k));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      halted <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      halted <= halted_next;
      done   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_q    <= opcode;
      key_q   <= key_in;
      wdata_q <= wdata_in;
      bdata_q <= bdata_in;
      for (int i = 0; i < ENTRIES; i++) begin
        match_q[i] <= stat[i].match;
        repl_q[i]  <= stat[i].repl;
      end
    end
    if (done_next) begin
      rd       <= rd_next;
      hit_q    <= hit_next;
      chg_q    <= chg_next;
      status_q <= status_next;
    end
  end

  always_comb begin
    state_next  = state;
    halted_next = halted;
    done_next   = 1'b0;
    move        = 1'b0;
    new_value   = hit_val;
    new_dirty   = hit_dirty;
    rd_next     = '0;
    hit_next    = 1'b0;
    chg_next    = 1'b0;
    status_next = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        state_next = ST_IDLE;
        done_next  = 1'b1;
        priority if (halted) begin
          status_next = 1'b1;
        end else if (any_hit) begin
          move = 1'b1;
          if (is_write && (hit_val != wdata_q)) begin
            new_value = wdata_q;
            new_dirty = 1'b1;
          end
          rd_next     = new_value;
          hit_next    = 1'b1;
          chg_next    = new_dirty;
          status_next = 1'b0;
        end else if (!any_repl) begin
          halted_next = 1'b1;
          status_next = 1'b1;
        end else if (is_write && (wdata_q == bdata_q)) begin
          rd_next     = wdata_q;
          status_next = 1'b0;
        end else begin
          move        = 1'b1;
          new_value   = is_write ? wdata_q : bdata_q;
          new_dirty   = is_write;
          rd_next     = new_value;
          chg_next    = new_dirty;
          status_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    load = move ? sfx : '0;
  end

endmodule
`default_nettype wire

>>> rtl/lru_change_cache_unit.sv
// A start taken in idle moves the sequencer to busy; the result strobe is registered out of busy.
// A new word is not taken while busy; the compare across the cell row is
// registered when the word is taken, the shift toward the front runs next cycle.
// Reset: all cells empty, sequencer idle, result outputs not cleared; no clearing pass, ready at once.
// The receiver cannot stall: each result is strobed by done for one cycle only.
// Top level of the cell cache; depends on lcc_pkg, lcc_cell, lcc_ctrl.
`default_nettype none
module lru_change_cache_unit #(
  parameter int ENTRIES   = lcc_pkg::ENTRIES_DEF,
  parameter int ADDR_BITS = lcc_pkg::ADDR_BITS_DEF,
  parameter int DATA_BITS = lcc_pkg::DATA_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                opcode,
  input  wire logic [lcc_pkg::ADDR_W-1:0]          address,
  input  wire logic signed [lcc_pkg::DATA_W-1:0]   write_data,
  input  wire logic signed [lcc_pkg::DATA_W-1:0]   backing_data,
  output logic                                     done,
  output logic signed [lcc_pkg::DATA_W-1:0]        read_data,
  output logic                                     hit,
  output logic                                     entry_changed,
  output logic                                     status
);
  import lcc_pkg::*;

  logic [ADDR_BITS+ADDR_W-1:0]          addr_ext;
  logic [DATA_BITS+DATA_W-1:0]          wdata_ext, bdata_ext;
  logic [DATA_W+DATA_BITS-1:0]          rd_ext;
  logic [ADDR_BITS-1:0]                 key_in;
  logic [DATA_BITS-1:0]                 wdata_in, bdata_in, rd;

  logic [ENTRIES:0]                     chain_valid, chain_dirty;
  logic [ENTRIES:0][ADDR_BITS-1:0]      chain_key;
  logic [ENTRIES:0][DATA_BITS-1:0]      chain_value;
  cell_stat_t [ENTRIES-1:0]             stat;
  logic [ENTRIES-1:0]                   load;

  assign addr_ext  = {{ADDR_BITS{1'b0}}, address};
  assign wdata_ext = {{DATA_BITS{1'b0}}, write_data};
  assign bdata_ext = {{DATA_BITS{1'b0}}, backing_data};
  assign key_in    = addr_ext[ADDR_BITS-1:0];
  assign wdata_in  = wdata_ext[DATA_BITS-1:0];
  assign bdata_in  = bdata_ext[DATA_BITS-1:0];
  assign rd_ext    = {{DATA_W{1'b0}}, rd};
  assign read_data = rd_ext[DATA_W-1:0];

  assign chain_valid[0] = 1'b1;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lcc_cell #(
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .load       (load[i]),
      .prev_valid (chain_valid[i]),
      .prev_dirty (chain_dirty[i]),
      .prev_key   (chain_key[i]),
      .prev_value (chain_value[i]),
      .probe_key  (key_in),
      .valid      (chain_valid[i+1]),
      .dirty      (chain_dirty[i+1]),
      .key        (chain_key[i+1]),
      .value      (chain_value[i+1]),
      .stat       (stat[i])
    );
  end

  lcc_ctrl #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (opcode),
    .key_in    (key_in),
    .wdata_in  (wdata_in),
    .bdata_in  (bdata_in),
    .stat      (stat),
    .values    (chain_value[ENTRIES:1]),
    .busy      (busy),
    .load      (load),
    .new_key   (chain_key[0]),
    .new_value (chain_value[0]),
    .new_dirty (chain_dirty[0]),
    .done      (done),
    .rd        (rd),
    .hit_q     (hit),
    .chg_q     (entry_changed),
    .status_q  (status)
  );

endmodule
`default_nettype wire

>>> rtl/lcc_checker.sv
// Port-level checks for lru_change_cache_unit, attached by bind below.
// Depends on lcc_pkg.
`default_nettype none
module lcc_props (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             start,
  input wire logic                             busy,
  input wire logic                             done,
  input wire logic signed [lcc_pkg::DATA_W-1:0] read_data,
  input wire logic                             hit,
  input wire logic                             entry_changed,
  input wire logic                             status
);
  import lcc_pkg::*;

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("taken word did not raise busy");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("busy cycle not followed by a result");

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a word in flight");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    done && status |-> read_data == '0 && !hit && !entry_changed)
    else $error("out-of-space result not cleared");

  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> !status)
    else $error("hit reported with out-of-space status");

endmodule

bind lru_change_cache_unit lcc_props u_lcc_props (.*);
`default_nettype wire
